// File: hw/rtl/idac_pkg.sv
// Package: shared types and constants for the isochronous descriptor guard.
`default_nettype none
package idac_pkg;

	localparam int unsigned LEN_W   = 10;
	localparam int unsigned FRAME_W = 7;
	localparam int unsigned WIN_W   = 10;
	localparam int unsigned CFG_W   = 10;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned FLT_W   = 6;

	localparam logic [31:0] CTRL_MASK = 32'hfc00_0000;
	localparam logic [31:0] CTRL_ISO  = 32'h0400_0000;
	localparam logic [22:0] WIN_SIZE  = 23'h40_0000;
	localparam logic [LEN_W-1:0] FB_LEN = LEN_W'(4);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int unsigned ACTIVE_BIT = 31;

	localparam int unsigned F_NOARM    = 0;
	localparam int unsigned F_CONTROL  = 1;
	localparam int unsigned F_LENGTH   = 2;
	localparam int unsigned F_ADDRESS  = 3;
	localparam int unsigned F_PCM      = 4;
	localparam int unsigned F_FEEDBACK = 5;

	localparam logic [CIDX_W-1:0] REG_OUT_MAX_PACKET = 2'd0;
	localparam logic [CIDX_W-1:0] REG_FRAME_BYTES    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WINDOW_BASE    = 2'd2;

	typedef enum logic [1:0] {
		OP_ARM   = 2'd0,
		OP_CHECK = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               start;
		logic [LEN_W-1:0]   dividend;
		logic [FRAME_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic busy;
		logic rem_nz;
	} rem_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/idac_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module idac_rem_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire idac_pkg::rem_req_t req,
	output idac_pkg::rem_rsp_t     rsp
);

	localparam int unsigned DW  = idac_pkg::LEN_W;
	localparam int unsigned RW  = idac_pkg::FRAME_W;
	localparam int unsigned CW  = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsr_q;
	logic [RW:0]   trial;
	logic          take;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= take ? RW'(trial - {1'b0, dsr_q}) : trial[RW-1:0];
		end
	end

	assign rsp.busy   = cnt_q != '0;
	assign rsp.rem_nz = rem_q != '0;

endmodule
`default_nettype wire

// File: hw/rtl/iso_descriptor_arm_and_completion_check.sv
// Top level: arm and completion checker for two double-buffered iso endpoints.
//
// Input channel (in_valid/in_ready) takes one beat per item: arm, check or
// clear for one endpoint and bank. Output channel (out_valid/out_ready) gives
// exactly one result beat per item from an output register.
// A new item is taken only when the sequencer is idle. Arm, clear and most
// checks pass from accept through the evaluation step to the final step. A
// completion check of the audio OUT endpoint that needs the frame-size test
// also runs the remainder unit, one bit per cycle over the 10-bit byte count.
// The sequencer waits in its final step while the output register holds an
// untaken beat; the input side is free again once that result is loaded, so
// the next item is taken while a finished result still waits for out_ready.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user makes
// them only while no item is in flight, as the block does not enforce this.
// Reset clears armed marks, fault counters, the sequencer and the output
// valid; configuration returns to 192 / 4 / 128. Recorded commands are not
// cleared and are meaningful only once armed.
`default_nettype none
module iso_descriptor_arm_and_completion_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        endpoint_sel,
	input  wire logic        bank,
	input  wire logic [31:0] buffer_address,
	input  wire logic [9:0]  arm_length,
	input  wire logic [31:0] descriptor_word,
	input  wire logic        checking_enabled,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             arm_ok,
	output logic [31:0]      command_word,
	output logic [5:0]       fault_bits,
	output logic [31:0]      returned_word,
	output logic [15:0]      failure_count
);

	localparam int unsigned LW = idac_pkg::LEN_W;
	localparam int unsigned FW = idac_pkg::FLT_W;
	localparam int unsigned NW = idac_pkg::CNT_W;

	idac_pkg::state_t state_q, state_d;

	logic [LW-1:0]                   omp_q;
	logic [idac_pkg::FRAME_W-1:0]    frame_q;
	logic [idac_pkg::WIN_W-1:0]      winb_q;

	idac_pkg::op_t  op_q;
	logic           ep_q, bk_q, en_q;
	logic [31:0]    addr_q, word_q;
	logic [LW-1:0]  len_q;

	logic [31:0]        cmd_mem_q [4];
	logic [1:0][1:0]    marks_q;
	logic [NW-1:0]      cnt_q [2];

	logic [FW-1:0]  flt_q;
	logic           pcm_need_q, arm_ok_q;
	logic [31:0]    cmd_q;

	logic             out_valid_q;
	logic             ok_o_q;
	logic [31:0]      cmd_o_q, ret_o_q;
	logic [FW-1:0]    flt_o_q;
	logic [NW-1:0]    cnt_o_q;

	idac_pkg::rem_req_t rem_req;
	idac_pkg::rem_rsp_t rem_rsp;

	logic              accept, load_out, eval;
	logic [31:0]       armed;
	logic [LW-1:0]     remaining, capacity, moved, need;
	logic [15:0]       got, base, a_floor, a_ceil, a_one;
	logic              len_flt, addr_ok, checked;
	logic [FW-1:0]     flt_eval, flt_fin;
	logic [22:0]       span;
	logic              arm_bad;
	logic [NW-1:0]     cnt_new;

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == idac_pkg::ST_IDLE;
	assign eval     = state_q == idac_pkg::ST_EVAL;
	assign load_out = state_q == idac_pkg::ST_DONE && (!out_valid_q || out_ready);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omp_q   <= LW'(192);
			frame_q <= idac_pkg::FRAME_W'(4);
			winb_q  <= idac_pkg::WIN_W'(128);
		end else if (cfg_we) begin
			case (cfg_index)
				idac_pkg::REG_OUT_MAX_PACKET: omp_q   <= cfg_data[LW-1:0];
				idac_pkg::REG_FRAME_BYTES:    frame_q <= cfg_data[idac_pkg::FRAME_W-1:0];
				idac_pkg::REG_WINDOW_BASE:    winb_q  <= cfg_data[idac_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= idac_pkg::op_t'(operation);
			ep_q   <= endpoint_sel;
			bk_q   <= bank;
			addr_q <= buffer_address;
			len_q  <= arm_length;
			word_q <= descriptor_word;
			en_q   <= checking_enabled;
		end
	end

	// check evaluation
	always_comb begin
		armed     = cmd_mem_q[{ep_q, bk_q}];
		remaining = word_q[25:16];
		capacity  = armed[25:16];
		got       = word_q[15:0];
		base      = armed[15:0];
		moved     = capacity - remaining;
		len_flt   = remaining > capacity;
		a_floor   = base + 16'(moved[LW-1:6]);
		a_ceil    = a_floor + 16'(moved[5:0] != '0);
		a_one     = base + 16'd1;
		addr_ok   = (got == a_floor) || (!ep_q && got == a_ceil) ||
			(ep_q && capacity == idac_pkg::FB_LEN && remaining == '0 && got == a_one);
		checked   = op_q == idac_pkg::OP_CHECK && !word_q[idac_pkg::ACTIVE_BIT] && en_q;
		flt_eval  = '0;
		flt_eval[idac_pkg::F_NOARM]    = !marks_q[ep_q][bk_q];
		flt_eval[idac_pkg::F_CONTROL]  = (word_q & idac_pkg::CTRL_MASK) != idac_pkg::CTRL_ISO;
		flt_eval[idac_pkg::F_LENGTH]   = len_flt;
		flt_eval[idac_pkg::F_ADDRESS]  = !len_flt && !addr_ok;
		flt_eval[idac_pkg::F_FEEDBACK] = ep_q && remaining != '0;
		if (!checked) begin
			flt_eval = '0;
		end
	end

	// arm evaluation
	always_comb begin
		need    = ep_q ? idac_pkg::FB_LEN : omp_q;
		span    = {1'b0, addr_q[21:0]} + 23'(len_q);
		arm_bad = addr_q[5:0] != '0 || addr_q[31:22] != winb_q ||
			span > idac_pkg::WIN_SIZE || len_q != need ||
			word_q[idac_pkg::ACTIVE_BIT];
	end

	assign rem_req.start    = eval;
	assign rem_req.dividend = moved;
	assign rem_req.divisor  = frame_q;

	idac_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk) begin
		if (eval) begin
			flt_q      <= flt_eval;
			pcm_need_q <= checked && !ep_q && !len_flt && frame_q != '0;
			arm_ok_q   <= op_q == idac_pkg::OP_ARM && !arm_bad;
			cmd_q      <= {1'b1, 4'b0000, 1'b1, len_q, addr_q[21:6]};
		end
		if (eval && op_q == idac_pkg::OP_ARM && !arm_bad) begin
			cmd_mem_q[{ep_q, bk_q}] <= {1'b1, 4'b0000, 1'b1, len_q, addr_q[21:6]};
		end
	end

	always_comb begin
		flt_fin = flt_q;
		flt_fin[idac_pkg::F_PCM] = pcm_need_q && rem_rsp.rem_nz;
		cnt_new = cnt_q[ep_q];
		if (flt_fin != '0 && cnt_q[ep_q] != idac_pkg::CNT_MAX) begin
			cnt_new = cnt_q[ep_q] + NW'(1);
		end
	end

	// armed marks and fault counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else begin
			if (eval && op_q == idac_pkg::OP_ARM && !arm_bad) begin
				marks_q[ep_q][bk_q] <= 1'b1;
			end
			if (eval && op_q == idac_pkg::OP_CLEAR) begin
				marks_q[ep_q] <= '0;
			end
			if (load_out) begin
				cnt_q[ep_q] <= cnt_new;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			idac_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = idac_pkg::ST_EVAL;
				end
			end
			idac_pkg::ST_EVAL: begin
				state_d = (checked && !ep_q && !len_flt && frame_q != '0) ?
					idac_pkg::ST_MOD : idac_pkg::ST_DONE;
			end
			idac_pkg::ST_MOD: begin
				if (!rem_rsp.busy) begin
					state_d = idac_pkg::ST_DONE;
				end
			end
			idac_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = idac_pkg::ST_IDLE;
				end
			end
			default: state_d = idac_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_o_q  <= arm_ok_q;
			cmd_o_q <= arm_ok_q ? cmd_q : '0;
			flt_o_q <= flt_fin;
			ret_o_q <= op_q != idac_pkg::OP_CHECK ? '0 :
				(flt_fin != '0 ? (word_q | 32'h8000_0000) : word_q);
			cnt_o_q <= cnt_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign arm_ok        = ok_o_q;
	assign command_word  = cmd_o_q;
	assign fault_bits    = flt_o_q;
	assign returned_word = ret_o_q;
	assign failure_count = cnt_o_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == idac_pkg::ST_EVAL)
		else $error("accepted item did not enter evaluation");

	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == idac_pkg::ST_MOD && !rem_rsp.busy |=> state_q == idac_pkg::ST_DONE)
		else $error("sequencer stuck after remainder finished");

	a_cnt_mono0: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q[0] >= $past(cnt_q[0]))
		else $error("fault counter 0 decreased");

	a_cnt_mono1: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q[1] >= $past(cnt_q[1]))
		else $error("fault counter 1 decreased");

	a_arm_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arm_ok |-> fault_bits == '0 && returned_word == '0)
		else $error("arm result carries check fields");

endmodule
`default_nettype wire

// File: tb/tb_iso_descriptor_arm_and_completion_check.sv
// Testbench for the iso descriptor guard: arm/check/clear traffic checked against an in-bench model.
`timescale 1ns / 1ps

module tb_iso_descriptor_arm_and_completion_check;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PHASE_ITEMS = 116;

	typedef struct packed {
		idac_pkg::op_t op;
		logic          ep;
		logic          bk;
		logic [31:0]   addr;
		logic [9:0]    len;
		logic [31:0]   word;
		logic          en;
	} guard_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] cmd;
		logic [5:0]  flt;
		logic [31:0] ret;
		logic [15:0] cnt;
	} guard_reply_t;

	class descriptor_ledger;
		logic [9:0]   pkt_len;
		logic [6:0]   frame_size;
		logic [9:0]   win_base;
		logic [31:0]  cmds [4];
		bit           written [4];
		logic [1:0]   marks [2];
		logic [15:0]  fails [2];
		guard_reply_t due [$];
		int unsigned  errors;

		function new();
			pkt_len = 10'd192;
			frame_size = 7'd4;
			win_base = 10'd128;
			for (int i = 0; i < 4; i++) begin
				cmds[i] = '0;
				written[i] = 1'b0;
			end
			for (int i = 0; i < 2; i++) begin
				marks[i] = '0;
				fails[i] = '0;
			end
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] data);
			case (idx)
				idac_pkg::REG_OUT_MAX_PACKET: pkt_len = data;
				idac_pkg::REG_FRAME_BYTES: frame_size = data[6:0];
				idac_pkg::REG_WINDOW_BASE: win_base = data;
				default: ;
			endcase
		endfunction

		function logic [5:0] completion_faults(logic ep, logic bk, logic [31:0] word);
			logic [31:0] armed;
			int unsigned remaining, capacity, got, base_addr, moved;
			logic [5:0] f;
			bit fits;
			armed = cmds[{ep, bk}];
			remaining = word[25:16];
			capacity = armed[25:16];
			got = word[15:0];
			base_addr = armed[15:0];
			f = '0;
			if (!marks[ep][bk])
				f[idac_pkg::F_NOARM] = 1'b1;
			if ((word & idac_pkg::CTRL_MASK) != idac_pkg::CTRL_ISO)
				f[idac_pkg::F_CONTROL] = 1'b1;
			if (remaining > capacity) begin
				f[idac_pkg::F_LENGTH] = 1'b1;
			end else begin
				moved = capacity - remaining;
				fits = got == ((base_addr + moved / 64) & 32'hffff);
				if (!ep && got == ((base_addr + (moved + 63) / 64) & 32'hffff))
					fits = 1'b1;
				if (ep && capacity == 4 && remaining == 0 && got == ((base_addr + 1) & 32'hffff))
					fits = 1'b1;
				if (!fits)
					f[idac_pkg::F_ADDRESS] = 1'b1;
				if (!ep && frame_size != 0 && (moved % frame_size) != 0)
					f[idac_pkg::F_PCM] = 1'b1;
			end
			if (ep && remaining != 0)
				f[idac_pkg::F_FEEDBACK] = 1'b1;
			return f;
		endfunction

		function void record_item(guard_item_t it);
			guard_reply_t r;
			logic [9:0] need;
			int unsigned low22;
			r = '0;
			case (it.op)
				idac_pkg::OP_ARM: begin
					need = it.ep ? idac_pkg::FB_LEN : pkt_len;
					low22 = it.addr[21:0];
					if (it.addr[5:0] == 6'd0 && it.addr[31:22] == win_base &&
					    low22 + it.len <= 32'h40_0000 && it.len == need && !it.word[31]) begin
						r.cmd = {1'b1, 4'd0, 1'b1, it.len, it.addr[21:6]};
						r.ok = 1'b1;
						cmds[{it.ep, it.bk}] = r.cmd;
						written[{it.ep, it.bk}] = 1'b1;
						marks[it.ep][it.bk] = 1'b1;
					end
				end
				idac_pkg::OP_CHECK: begin
					r.ret = it.word;
					if (!it.word[31] && it.en) begin
						r.flt = completion_faults(it.ep, it.bk, it.word);
						if (r.flt != '0) begin
							if (fails[it.ep] != idac_pkg::CNT_MAX)
								fails[it.ep] = fails[it.ep] + 16'd1;
							r.ret[31] = 1'b1;
						end
					end
				end
				idac_pkg::OP_CLEAR: marks[it.ep] = '0;
				default: ;
			endcase
			r.cnt = fails[it.ep];
			due.push_back(r);
		endfunction

		function void compare_beat(guard_reply_t got);
			guard_reply_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: ok=%0d cmd=%h flt=%h ret=%h cnt=%0d",
						got.ok, got.cmd, got.flt, got.ret, got.cnt);
				return;
			end
			want = due.pop_front();
			if (got.ok !== want.ok || got.cmd !== want.cmd || got.flt !== want.flt ||
			    got.ret !== want.ret || got.cnt !== want.cnt) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch want: ok=%0d cmd=%h flt=%h ret=%h cnt=%0d",
						want.ok, want.cmd, want.flt, want.ret, want.cnt);
					$display("          got: ok=%0d cmd=%h flt=%h ret=%h cnt=%0d",
						got.ok, got.cmd, got.flt, got.ret, got.cnt);
				end
			end
		endfunction

		function void close_out();
			if (due.size() != 0) begin
				$display("%0d result beats never arrived", due.size());
				errors += due.size();
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = idac_pkg::REG_OUT_MAX_PACKET;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = idac_pkg::OP_NONE;
	logic        endpoint_sel = 1'b0;
	logic        bank = 1'b0;
	logic [31:0] buffer_address = '0;
	logic [9:0]  arm_length = '0;
	logic [31:0] descriptor_word = '0;
	logic        checking_enabled = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        arm_ok;
	logic [31:0] command_word;
	logic [5:0]  fault_bits;
	logic [31:0] returned_word;
	logic [15:0] failure_count;

	descriptor_ledger ledger = new();
	guard_reply_t     seen;
	int unsigned      gap_pct = 0;
	int unsigned      stall_pct = 0;
	int unsigned      sent = 0;
	int unsigned      cycles = 0;

	iso_descriptor_arm_and_completion_check u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.endpoint_sel(endpoint_sel),
		.bank(bank),
		.buffer_address(buffer_address),
		.arm_length(arm_length),
		.descriptor_word(descriptor_word),
		.checking_enabled(checking_enabled),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.arm_ok(arm_ok),
		.command_word(command_word),
		.fault_bits(fault_bits),
		.returned_word(returned_word),
		.failure_count(failure_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.ok = arm_ok;
			seen.cmd = command_word;
			seen.flt = fault_bits;
			seen.ret = returned_word;
			seen.cnt = failure_count;
			ledger.compare_beat(seen);
		end
	end

	function automatic guard_item_t blank_item(idac_pkg::op_t op, logic ep, logic bk);
		guard_item_t it;
		it.op = op;
		it.ep = ep;
		it.bk = bk;
		it.addr = $urandom;
		it.len = 10'($urandom);
		it.word = $urandom;
		it.en = 1'($urandom);
		return it;
	endfunction

	function automatic guard_item_t arm_item(logic ep, logic bk, int unsigned flaw);
		guard_item_t it;
		logic [9:0] need;
		int unsigned top, low;
		it = blank_item(idac_pkg::OP_ARM, ep, bk);
		need = ep ? idac_pkg::FB_LEN : ledger.pkt_len;
		top = (32'h40_0000 - need) >> 6;
		case ($urandom_range(7))
			0: low = 0;
			1: low = top;
			default: low = $urandom_range(top);
		endcase
		it.addr = {ledger.win_base, 22'(low << 6)};
		it.len = need;
		it.word[31] = 1'b0;
		case (flaw)
			1: it.addr[5:0] = 6'($urandom_range(63, 1));
			2: it.addr[31:22] = ledger.win_base + 10'($urandom_range(1023, 1));
			3: begin
				if (need > 64)
					it.addr[21:0] = 22'($urandom_range(65535, top + 1) << 6);
				else
					it.len = need + 10'($urandom_range(1023, 1));
			end
			4: it.len = need + 10'($urandom_range(1023, 1));
			5: it.word[31] = 1'b1;
			default: ;
		endcase
		return it;
	endfunction

	function automatic int unsigned pick_moved(logic ep, logic bk);
		int unsigned capacity;
		capacity = ledger.cmds[{ep, bk}][25:16];
		if (ep)
			return ($urandom_range(3) != 0) ? capacity : $urandom_range(capacity);
		if (ledger.frame_size != 0 && $urandom_range(3) != 0)
			return $urandom_range(capacity / ledger.frame_size) * ledger.frame_size;
		return $urandom_range(capacity);
	endfunction

	function automatic guard_item_t check_item(logic ep, logic bk, int unsigned moved,
			int unsigned form, int unsigned flaw);
		guard_item_t it;
		logic [31:0] cmd;
		int unsigned capacity, remaining;
		logic [15:0] got;
		it = blank_item(idac_pkg::OP_CHECK, ep, bk);
		if (!ledger.written[{ep, bk}]) begin
			it.word[31] = 1'b1;
			return it;
		end
		cmd = ledger.cmds[{ep, bk}];
		capacity = cmd[25:16];
		if (moved > capacity)
			moved = capacity;
		remaining = capacity - moved;
		case (form)
			1: got = cmd[15:0] + 16'((moved + 63) / 64);
			2: got = cmd[15:0] + 16'd1;
			default: got = cmd[15:0] + 16'(moved / 64);
		endcase
		it.word = idac_pkg::CTRL_ISO | {6'd0, 10'(remaining), got};
		it.en = 1'b1;
		case (flaw)
			1: begin
				it.word[30:26] = 5'($urandom_range(31));
				if (it.word[30:26] == 5'd1)
					it.word[30:26] = 5'd0;
			end
			2: begin
				if (capacity < 1023)
					it.word[25:16] = 10'($urandom_range(1023, capacity + 1));
				else
					it.word[15:0] = it.word[15:0] ^ 16'($urandom_range(65535, 1));
			end
			3: it.word[15:0] = it.word[15:0] ^ 16'($urandom_range(65535, 1));
			4: it.word[25:16] = 10'($urandom_range(1023, 1));
			default: ;
		endcase
		return it;
	endfunction

	task automatic send(guard_item_t it);
		logic taken;
		if (it.op == idac_pkg::OP_CHECK && !it.word[31] && it.en &&
		    !ledger.written[{it.ep, it.bk}])
			it.word[31] = 1'b1;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		endpoint_sel <= it.ep;
		bank <= it.bk;
		buffer_address <= it.addr;
		arm_length <= it.len;
		descriptor_word <= it.word;
		checking_enabled <= it.en;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		ledger.record_item(it);
		sent++;
	endtask

	// hold the sender until every result beat has drained
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.due.size() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		ledger.set_reg(idx, data);
	endtask

	task automatic directed_items();
		guard_item_t it;
		it = blank_item(idac_pkg::OP_CHECK, 1'b0, 1'b0);
		it.word[31] = 1'b1;
		send(it);
		it = blank_item(idac_pkg::OP_CHECK, 1'b1, 1'b1);
		it.word[31] = 1'b0;
		it.en = 1'b0;
		send(it);
		send(blank_item(idac_pkg::OP_NONE, 1'b1, 1'b0));
		it = arm_item(1'b0, 1'b0, 0);
		it.addr[21:0] = 22'h0;
		send(it);
		it = arm_item(1'b0, 1'b1, 0);
		it.addr[21:0] = 22'h3f_ff40;
		send(it);
		send(arm_item(1'b1, 1'b0, 0));
		send(arm_item(1'b1, 1'b1, 0));
		for (int f = 1; f <= 5; f++)
			send(arm_item(1'b0, 1'b0, f));
		send(check_item(1'b0, 1'b0, 192, 0, 0));
		send(check_item(1'b0, 1'b0, 130, 1, 0));
		send(check_item(1'b0, 1'b0, 130, 0, 0));
		send(check_item(1'b0, 1'b1, 192, 0, 2));
		send(check_item(1'b0, 1'b1, 192, 0, 1));
		send(check_item(1'b0, 1'b1, 64, 0, 3));
		send(check_item(1'b1, 1'b0, 4, 2, 0));
		send(check_item(1'b1, 1'b1, 4, 0, 4));
		send(blank_item(idac_pkg::OP_CLEAR, 1'b0, 1'b0));
		send(check_item(1'b0, 1'b0, 192, 0, 0));
		send(check_item(1'b1, 1'b0, 4, 0, 0));
		send(blank_item(idac_pkg::OP_CLEAR, 1'b1, 1'b1));
	endtask

	task automatic random_items(int unsigned count);
		int unsigned goal, pick, flaw;
		logic ep, bk;
		goal = sent + count;
		while (sent < goal) begin
			pick = $urandom_range(99);
			ep = 1'($urandom);
			bk = 1'($urandom);
			if (pick < 3) begin
				settle();
			end else if (pick < 53) begin
				send(arm_item(ep, bk, ($urandom_range(9) == 0) ? $urandom_range(5, 1) : 0));
				repeat ($urandom_range(3, 1)) begin
					if ($urandom_range(9) == 0)
						send(blank_item(idac_pkg::OP_CLEAR, ep, bk));
					flaw = ($urandom_range(9) < 7) ? 0 : $urandom_range(4, 1);
					send(check_item(ep, bk, pick_moved(ep, bk), $urandom_range(2), flaw));
				end
			end else if (pick < 62) begin
				send(arm_item(ep, bk, $urandom_range(5, 1)));
			end else if (pick < 70) begin
				send(blank_item(idac_pkg::OP_CLEAR, ep, bk));
			end else if (pick < 75) begin
				send(blank_item(idac_pkg::OP_NONE, ep, bk));
			end else if (pick < 85) begin
				send(check_item(ep, bk, pick_moved(ep, bk), $urandom_range(2),
					$urandom_range(4)));
			end else begin
				send(blank_item(idac_pkg::op_t'($urandom_range(3)), ep, bk));
			end
		end
	endtask

	initial begin
		int unsigned plan_packet [8];
		int unsigned plan_frame [8];
		int unsigned plan_window [8];
		plan_packet = '{192, 1, 1023, 480, 4, 1023, 77, 192};
		plan_frame = '{4, 1, 64, 3, 0, 1, 64, 48};
		plan_window = '{128, 0, 1023, 517, 1, 0, 300, 128};
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				settle();
				repeat (20) @(posedge clk);
				write_reg(idac_pkg::REG_OUT_MAX_PACKET, 10'(plan_packet[p]));
				write_reg(idac_pkg::REG_FRAME_BYTES, 10'(plan_frame[p]));
				write_reg(idac_pkg::REG_WINDOW_BASE, 10'(plan_window[p]));
			end
			case (p % 4)
				1: begin
					gap_pct = 81;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 81;
				end
				3: begin
					gap_pct = 23;
					stall_pct = 23;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			if (p == 0)
				directed_items();
			random_items(PHASE_ITEMS);
		end
		settle();
		repeat (30) @(posedge clk);
		ledger.close_out();
		if (ledger.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
